// File: rtl/assert_macros.svh
// Assertion helpers used by index_node_integrity_checker to check itself.
// Every check is sampled on the rising clock edge and is off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/inic_pkg.sv
package inic_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 48;
  localparam int unsigned FILE_END_W      = 48;
  localparam int unsigned NODE_SIZE_W     = 16;
  localparam int unsigned KEY_CNT_W       = 16;
  localparam int unsigned CRC_W           = 32;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned CMD_FIFO_DEPTH  = 4;

  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 5;

  localparam logic [CRC_W-1:0]       CRC_POLY       = 32'hedb88320;
  localparam logic [NODE_SIZE_W-1:0] NODE_SIZE_RST  = 16'd8192;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] REG_FILE_END  = 2'd0;
  localparam logic [1:0] REG_NODE_SIZE = 2'd1;
  localparam logic [1:0] REG_CRC_EN    = 2'd2;

  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_BYTE   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK_UNCHECKED = 2'd0,
    ST_CRC_MATCH    = 2'd1,
    ST_CORRUPT      = 2'd2,
    ST_CRC_MISMATCH = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_CORRUPT   = 2'd0,
    CMD_UNCHECKED = 2'd1,
    CMD_COLLECT   = 2'd2,
    CMD_BYTE      = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [KEY_CNT_W-1:0]  key_cnt;
    logic [CRC_W-1:0]      crc;
    logic [BYTE_W-1:0]     data;
  } cmd_t;

  typedef struct packed {
    logic [FILE_END_W-1:0]  file_end;
    logic [NODE_SIZE_W-1:0] node_size;
    logic                   crc_en;
  } cfg_t;

  // One byte of a reflected CRC-32, processed bit by bit.
  function automatic logic [CRC_W-1:0] crc_byte(logic [CRC_W-1:0] crc,
                                                logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c ^ (crc >> 8);
  endfunction

endpackage

// File: rtl/inic_in_if.sv
interface inic_in_if import inic_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [OFFSET_BITS-1:0] right_sibling;
  logic [OFFSET_BITS-1:0] left_sibling;
  logic [KEY_CNT_W-1:0]   key_byte_count;
  logic [CRC_W-1:0]       stored_crc;
  logic [BYTE_W-1:0]      data_byte;

  modport source (
    output valid, operation, right_sibling, left_sibling, key_byte_count, stored_crc,
           data_byte,
    input  ready
  );
  modport sink (
    input  valid, operation, right_sibling, left_sibling, key_byte_count, stored_crc,
           data_byte,
    output ready
  );
endinterface

// File: rtl/inic_out_if.sv
interface inic_out_if import inic_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [CRC_W-1:0] computed_crc;

  modport source (output valid, status, computed_crc, input ready);
  modport sink   (input valid, status, computed_crc, output ready);
endinterface

// File: rtl/index_node_integrity_checker.sv
// Channel   Dir  Handshake      Payload
// req_i     in   valid/ready    operation, right_sibling, left_sibling,
//                               key_byte_count, stored_crc, data_byte
// res_o     out  valid/ready    status, computed_crc
// apb       in   psel/penable   paddr, pwdata, prdata (pready tied high)
//
// Key bytes are taken one per cycle while no header is being checked and the queue
// has room; a byte that ends a collection gives its result through the output register.
// A header that fails the range or key count tests is queued in the cycle it is taken;
// any other header holds the front while the bit-serial remainder unit checks both
// sibling offsets against the node size, and until its command is queued.
// A four-entry command queue lets the front keep working while res_o stalls.
// rst_ni clears all control state at once; no clearing pass follows reset.
module index_node_integrity_checker import inic_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  inic_in_if.sink               req_i,
  inic_out_if.source            res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  `include "assert_macros.svh"

  logic [FILE_END_W-1:0]  file_end_q;
  logic [NODE_SIZE_W-1:0] node_size_q;
  logic                   crc_en_q;
  logic [1:0]             reg_idx;
  logic                   wr_en;
  cfg_t                   cfg;
  cmd_t                   push_cmd, head_cmd;
  logic                   q_push, q_full, q_pop, q_empty;
  logic                   res_no_crc, hdr_wait;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_end_q  <= '0;
      node_size_q <= NODE_SIZE_RST;
      crc_en_q    <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FILE_END:  file_end_q  <= pwdata[FILE_END_W-1:0];
        REG_NODE_SIZE: node_size_q <= pwdata[NODE_SIZE_W-1:0];
        REG_CRC_EN:    crc_en_q    <= pwdata[0];
        default:       crc_en_q    <= crc_en_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FILE_END:  prdata = APB_DATA_W'(file_end_q);
      REG_NODE_SIZE: prdata = APB_DATA_W'(node_size_q);
      REG_CRC_EN:    prdata = APB_DATA_W'(crc_en_q);
      default:       prdata = '0;
    endcase
  end

  assign cfg = '{file_end: file_end_q, node_size: node_size_q, crc_en: crc_en_q};

  inic_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cfg_i  (cfg),
    .full_i (q_full),
    .push_o (q_push),
    .cmd_o  (push_cmd)
  );

  inic_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (head_cmd),
    .empty_o (q_empty)
  );

  inic_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (head_cmd),
    .pop_o       (q_pop),
    .res_o       (res_o)
  );

  assign res_no_crc = res_o.valid &&
                      (res_o.status == ST_CORRUPT || res_o.status == ST_OK_UNCHECKED);
  assign hdr_wait   = req_i.valid && req_i.ready && (req_i.operation == OP_HEADER) &&
                      !q_push;

  `ASSERT_IMPL(a_no_overflow, q_push, !q_full, "command pushed into a full queue")
  `ASSERT_IMPL(a_no_underflow, q_pop, !q_empty, "command popped from an empty queue")
  `ASSERT_IMPL(a_zero_crc_unchecked, res_no_crc, res_o.computed_crc == '0, "nonzero CRC")
  `ASSERT_NEXT(a_hdr_blocks_front, hdr_wait, !req_i.ready, "front took a request early")

endmodule

// File: rtl/inic_front.sv
module inic_front import inic_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  inic_in_if.sink    req_i,
  input  cfg_t       cfg_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  localparam int unsigned CMP_W = (OFFSET_BITS > FILE_END_W) ? OFFSET_BITS : FILE_END_W;
  localparam int unsigned LIM_W = (OFFSET_BITS < FILE_END_W) ? OFFSET_BITS : FILE_END_W;
  localparam int unsigned CNT_W = $clog2(OFFSET_BITS + 1);

  localparam logic [1:0] FS_IDLE = 2'd0;
  localparam logic [1:0] FS_DIV  = 2'd1;
  localparam logic [1:0] FS_PUSH = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [OFFSET_BITS-1:0] rs_q, ls_q;
  logic [NODE_SIZE_W-1:0] rem_r_q, rem_l_q;
  logic [KEY_CNT_W-1:0]   kb_q;
  logic [CRC_W-1:0]       sc_q;
  logic                   chk_q;

  logic             ready, acc, is_hdr;
  logic [CMP_W-1:0] lim, rs_ext, ls_ext;
  logic             cheap_bad;

  // One restoring step of the remainder: bring in the next offset bit.
  function automatic logic [NODE_SIZE_W-1:0] rem_step(logic [NODE_SIZE_W-1:0] r,
                                                      logic b,
                                                      logic [NODE_SIZE_W-1:0] d);
    logic [NODE_SIZE_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[NODE_SIZE_W-1:0];
  endfunction

  assign ready       = (state_q == FS_IDLE) && !full_i;
  assign req_i.ready = ready;
  assign acc         = req_i.valid && ready;
  assign is_hdr      = (req_i.operation == OP_HEADER);

  assign lim    = CMP_W'(cfg_i.file_end[LIM_W-1:0]);
  assign rs_ext = CMP_W'(req_i.right_sibling);
  assign ls_ext = CMP_W'(req_i.left_sibling);

  // A zero node size always fails the key count test, so a header with a zero node
  // size never reaches the remainder unit.
  assign cheap_bad = (rs_ext > lim) || (ls_ext > lim) ||
                     (req_i.key_byte_count == '0) ||
                     (req_i.key_byte_count > cfg_i.node_size);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      FS_IDLE: begin
        if (acc) begin
          if (!is_hdr) begin
            push_o     = 1'b1;
            cmd_o.kind = CMD_BYTE;
            cmd_o.data = req_i.data_byte;
          end else if (cheap_bad) begin
            push_o     = 1'b1;
            cmd_o.kind = CMD_CORRUPT;
          end else begin
            state_d = FS_DIV;
            cnt_d   = CNT_W'(OFFSET_BITS);
          end
        end
      end
      FS_DIV: begin
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (!full_i) begin
          push_o        = 1'b1;
          cmd_o.key_cnt = kb_q;
          cmd_o.crc     = sc_q;
          if ((rem_r_q != '0) || (rem_l_q != '0)) begin
            cmd_o.kind = CMD_CORRUPT;
          end else if (chk_q) begin
            cmd_o.kind = CMD_COLLECT;
          end else begin
            cmd_o.kind = CMD_UNCHECKED;
          end
          state_d = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && is_hdr) begin
      rs_q    <= req_i.right_sibling;
      ls_q    <= req_i.left_sibling;
      rem_r_q <= '0;
      rem_l_q <= '0;
      kb_q    <= req_i.key_byte_count;
      sc_q    <= req_i.stored_crc;
      chk_q   <= cfg_i.crc_en && (req_i.stored_crc != '0);
    end else if (state_q == FS_DIV) begin
      rs_q    <= rs_q << 1;
      ls_q    <= ls_q << 1;
      rem_r_q <= rem_step(rem_r_q, rs_q[OFFSET_BITS-1], cfg_i.node_size);
      rem_l_q <= rem_step(rem_l_q, ls_q[OFFSET_BITS-1], cfg_i.node_size);
    end
  end

endmodule

// File: rtl/inic_cmd_fifo.sv
module inic_cmd_fifo import inic_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = $clog2(CMD_FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t             mem_q [CMD_FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(CMD_FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

endmodule

// File: rtl/inic_back.sv
module inic_back import inic_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      pop_o,
  inic_out_if.source res_o
);

  logic                 collecting_q;
  logic [KEY_CNT_W-1:0] rem_q;
  logic [CRC_W-1:0]     crc_q, exp_q;
  logic                 out_valid_q;
  status_e              status_q;
  logic [CRC_W-1:0]     out_crc_q;

  logic             is_res, slot_free, last_byte;
  logic [CRC_W-1:0] crc_next;

  assign crc_next  = crc_byte(crc_q, cmd_i.data);
  assign last_byte = collecting_q && (rem_q == KEY_CNT_W'(1));

  always_comb begin
    unique case (cmd_i.kind) inside
      CMD_CORRUPT, CMD_UNCHECKED: is_res = 1'b1;
      CMD_COLLECT:                is_res = 1'b0;
      CMD_BYTE:                   is_res = last_byte;
      default:                    is_res = 1'b0;
    endcase
  end

  // A command with no result never waits on the output register.
  assign slot_free = !out_valid_q || res_o.ready;
  assign pop_o     = cmd_valid_i && (!is_res || slot_free);

  assign res_o.valid        = out_valid_q;
  assign res_o.status       = status_q;
  assign res_o.computed_crc = out_crc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      rem_q        <= '0;
      crc_q        <= '0;
      exp_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_o && is_res) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        unique case (cmd_i.kind) inside
          CMD_CORRUPT, CMD_UNCHECKED: begin
            collecting_q <= 1'b0;
            rem_q        <= '0;
            crc_q        <= '0;
          end
          CMD_COLLECT: begin
            collecting_q <= 1'b1;
            rem_q        <= cmd_i.key_cnt;
            crc_q        <= '0;
            exp_q        <= cmd_i.crc;
          end
          CMD_BYTE: begin
            if (collecting_q) begin
              crc_q <= crc_next;
              rem_q <= rem_q - KEY_CNT_W'(1);
              if (last_byte) begin
                collecting_q <= 1'b0;
              end
            end
          end
          default: begin
            collecting_q <= collecting_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && is_res) begin
      unique case (cmd_i.kind) inside
        CMD_CORRUPT: begin
          status_q  <= ST_CORRUPT;
          out_crc_q <= '0;
        end
        CMD_UNCHECKED: begin
          status_q  <= ST_OK_UNCHECKED;
          out_crc_q <= '0;
        end
        default: begin
          status_q  <= (crc_next == exp_q) ? ST_CRC_MATCH : ST_CRC_MISMATCH;
          out_crc_q <= crc_next;
        end
      endcase
    end
  end

endmodule
